@@ hdl/rtidq_pkg.sv @@
// Package for the record table block: record layout, operation codes and
// controller states. It depends on nothing and is used by record_table_insert_delete_query.
package rtidq_pkg;

   localparam int unsigned CODE_W  = 16;
   localparam int unsigned YEAR_W  = 12;
   localparam int unsigned PRICE_W = 24;
   localparam int unsigned COUNT_W = 7;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [YEAR_W-1:0]  year;
      logic [PRICE_W-1:0] price;
   } rec_type;

   localparam int unsigned REC_W = $bits(rec_type);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_YEAR   = 2'd2,
      FUNC_RANGE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/rtidq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing.
module rtidq_ram #(
   parameter int unsigned WIDTH = 52,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/record_table_insert_delete_query.sv @@
// Top level of the record table: controller, scan sequencer and result register.
// It depends on rtidq_pkg and instantiates rtidq_ram for the record storage.
//
// Each request item carries an operation in req_tuser and its operands in
// req_tdata. Insert appends a record, delete removes the first record with a
// matching code and closes the gap, and the two queries return every matching
// record in table order. Every request yields at least one response item, and
// the final one has rsp_tlast set.
// A request is taken only while the controller is idle. Insert, and any request
// on an empty table, go straight to the final response item. Delete and the
// queries read the table through the single RAM read port, one entry per cycle
// while the output is not stalled; a delete writes each later entry one place
// down as it streams past.
// Response items leave from an output register, so a new request may be taken
// while the last response still waits. When the receiver stalls, the scan
// holds its place and resumes without loss.
// Reset empties the table at once by clearing the count; the RAM keeps its
// contents, and entries at or above the count are never read.
module record_table_insert_delete_query
   import rtidq_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: item_code, item_year, item_price, price_low,
   // price_high, four zero bits.
   input  logic [103:0] req_tdata,
   // Fields from bit 0: func.
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: out_code, out_year, out_price, stored_count, five
   // zero bits.
   output logic [63:0]  rsp_tdata,
   // Fields from bit 0: status, hit.
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int unsigned AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CW-1:0]      count_ff;
   func_type           func_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [PRICE_W-1:0] plo_ff;
   logic [PRICE_W-1:0] phi_ff;
   logic               status_ff;
   logic               pend_vld_ff;
   rec_type            pend_rec_ff;
   logic [CW-1:0]      rd_idx_ff;
   logic               dat_vld_ff;
   logic [AW-1:0]      dat_idx_ff;

   logic               rsp_vld_ff;
   rec_type            rsp_rec_ff;
   logic               rsp_hit_ff;
   logic               rsp_status_ff;
   logic               rsp_last_ff;
   logic [COUNT_W-1:0] rsp_cnt_ff;

   func_type           req_func;
   rec_type            req_rec;
   rec_type            rd_rec;
   logic [REC_W-1:0]   rd_data;
   logic               req_fire;
   logic               out_free;
   logic               full;
   logic               is_query;
   logic               match;
   logic               del_match;
   logic               need_push;
   logic               proceed;
   logic               last_dat;
   logic               rd_en;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   rec_type            wr_rec;
   logic               push_mid;
   logic               push_fin;

   assign req_func       = func_type'(req_tuser);
   assign req_rec.code   = req_tdata[15:0];
   assign req_rec.year   = req_tdata[27:16];
   assign req_rec.price  = req_tdata[51:28];
   assign rd_rec         = rec_type'(rd_data);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign full       = (count_ff >= CW'(TABLE_DEPTH));
   assign is_query   = (func_ff == FUNC_YEAR) || (func_ff == FUNC_RANGE);
   assign del_match  = (rd_rec.code == code_ff);
   assign match      = (func_ff == FUNC_YEAR) ? (rd_rec.year == year_ff)
                     : ((rd_rec.price >= plo_ff) && (rd_rec.price <= phi_ff));
   assign need_push  = dat_vld_ff && is_query && match && pend_vld_ff;
   assign proceed    = !need_push || out_free;
   assign last_dat   = dat_vld_ff && (CW'(dat_idx_ff) == (count_ff - CW'(1)));
   assign rd_en      = (state_ff == ST_SCAN) && proceed && (rd_idx_ff < count_ff);
   assign push_mid   = (state_ff == ST_SCAN) && need_push && out_free;
   assign push_fin   = (state_ff == ST_FINISH) && out_free;

   rtidq_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_func == FUNC_INSERT) || (count_ff == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_dat && proceed) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_rec  = req_rec;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en = req_fire && (req_func == FUNC_INSERT) && !full;
         end
         ST_SCAN: begin
            wr_en   = dat_vld_ff && (func_ff == FUNC_DELETE) && pend_vld_ff;
            wr_addr = dat_idx_ff - AW'(1);
            wr_rec  = rd_rec;
         end
         ST_FINISH: begin
            wr_en = 1'b0;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         dat_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (req_fire) begin
            func_ff     <= req_func;
            code_ff     <= req_rec.code;
            year_ff     <= req_rec.year;
            plo_ff      <= req_tdata[75:52];
            phi_ff      <= req_tdata[99:76];
            status_ff   <= (req_func == FUNC_INSERT) && full;
            pend_vld_ff <= 1'b0;
            rd_idx_ff   <= '0;
            dat_vld_ff  <= 1'b0;
            if ((req_func == FUNC_INSERT) && !full) begin
               count_ff <= count_ff + CW'(1);
            end
         end

         if ((state_ff == ST_SCAN) && proceed) begin
            dat_vld_ff <= rd_en;
            if (rd_en) begin
               rd_idx_ff  <= rd_idx_ff + CW'(1);
               dat_idx_ff <= rd_idx_ff[AW-1:0];
            end
            if (dat_vld_ff) begin
               if (func_ff == FUNC_DELETE) begin
                  if (!pend_vld_ff && del_match) begin
                     pend_vld_ff <= 1'b1;
                     pend_rec_ff <= rd_rec;
                  end
                  if (last_dat && (pend_vld_ff || del_match)) begin
                     count_ff <= count_ff - CW'(1);
                  end
               end else if (match) begin
                  pend_vld_ff <= 1'b1;
                  pend_rec_ff <= rd_rec;
               end
            end
         end

         if (push_mid) begin
            rsp_vld_ff    <= 1'b1;
            rsp_rec_ff    <= pend_rec_ff;
            rsp_hit_ff    <= 1'b1;
            rsp_status_ff <= 1'b0;
            rsp_last_ff   <= 1'b0;
            rsp_cnt_ff    <= COUNT_W'(count_ff);
         end else if (push_fin) begin
            rsp_vld_ff    <= 1'b1;
            rsp_rec_ff    <= pend_vld_ff ? pend_rec_ff : '0;
            rsp_hit_ff    <= pend_vld_ff;
            rsp_status_ff <= status_ff;
            rsp_last_ff   <= 1'b1;
            rsp_cnt_ff    <= COUNT_W'(count_ff);
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_cnt_ff, rsp_rec_ff.price, rsp_rec_ff.year,
                        rsp_rec_ff.code};
   assign rsp_tuser  = {rsp_hit_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("Record count is above the table depth.");

   a_read_in_range : assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_idx_ff < count_ff))
      else $error("Scan read past the last held record.");

   a_no_write_finish : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !wr_en)
      else $error("Table written while the final item is pending.");

   a_finish_to_idle : assert property (@(posedge clock) disable iff (reset)
      push_fin |=> (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("Final item did not end the operation.");

   a_stall_holds_scan : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && !proceed) |=> $stable(rd_idx_ff) && dat_vld_ff)
      else $error("Scan moved while the output was stalled.");

endmodule
